[sv/hgcd_pkg.sv]
package hgcd_pkg;

    localparam int ITERS = 32;
    localparam int ZW = 36;
    localparam int ZU_W = 34;
    localparam int RADIUS_W = 26;
    localparam int DIST_W = 35;
    localparam int SCALE_W = 31;

    localparam logic signed [ZW:0] QUARTER_TURN = 37'sd14400000000;
    localparam logic signed [ZW:0] HALF_TURN = 37'sd28800000000;
    localparam logic signed [ZW:0] FULL_TURN = 37'sd57600000000;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 26'd6371000;
    localparam logic [SCALE_W-1:0] DIST_SCALE = 31'd1572052834;
    localparam logic [DIST_W-1:0] DIST_MAX = 35'd21082458350;
    localparam int DIST_SHIFT = 56;

    localparam logic signed [ZW-1:0] ATAN_TAB [ITERS] = '{
        36'sd7200000000, 36'sd4250408188, 36'sd2245798955, 36'sd1140002616,
        36'sd572213500, 36'sd286385697, 36'sd143227794, 36'sd71618267,
        36'sd35809680, 36'sd17904908, 36'sd8952463, 36'sd4476232,
        36'sd2238116, 36'sd1119058, 36'sd559529, 36'sd279765,
        36'sd139882, 36'sd69941, 36'sd34971, 36'sd17485,
        36'sd8743, 36'sd4371, 36'sd2186, 36'sd1093,
        36'sd546, 36'sd273, 36'sd137, 36'sd68,
        36'sd34, 36'sd17, 36'sd9, 36'sd4
    };

    typedef struct packed {
        logic                 neg;
        logic signed [ZW-1:0] r;
    } t_ang;

endpackage

[sv/haversine_great_circle_distance_core.sv]
// Channel   Direction  Ports                          Contents
// s         in         i_s_tvalid/o_s_tready/tdata    one pair of positions per item
// m         out        o_m_tvalid/i_m_tready/tdata    distance in centimeters
// cfg       in         i_cfg_valid/o_cfg_ready/data   sphere radius in meters
//
// One item is accepted every cycle unless a stalled result holds the pipeline.
// The pipeline is built from two 32-stage CORDIC pipelines, the root recurrence of
// ANGLE_FRAC_BITS + 1 stages and five two-stage multipliers in series.
// Reset is synchronous and active low; it clears valid bits and loads the default radius.
// A stalled result holds the pipeline only when the last stage also holds an item,
// so bubbles are squeezed out and input is still taken while a result waits.
module haversine_great_circle_distance_core import hgcd_pkg::*; #(
    parameter int ANGLE_FRAC_BITS = 30
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // here_lat[30:0], here_lon[62:31], point_lat[93:63], point_lon[125:94]
    input  logic [127:0]        i_s_tdata,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // distance_cm[34:0]
    output logic [39:0]         o_m_tdata,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [RADIUS_W-1:0] i_cfg_data
);

    localparam int F   = ANGLE_FRAC_BITS;
    localparam int XW  = F + 3;
    localparam int MW  = F + 2;
    localparam int NW  = 2 * F + 2;
    localparam int RW  = F + 4;
    localparam int PRW = RADIUS_W + ZU_W;
    localparam int LAT = F + 80;
    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};
    localparam logic signed [XW-1:0] GAIN = XW'(F >= 30 ?
        (64'd652032874 << (F >= 30 ? F - 30 : 0)) :
        (64'd652032874 >> (F < 30 ? 30 - F : 0)));

    function automatic t_ang fold(input logic signed [ZW-1:0] a);
        logic signed [ZW:0] r;
        t_ang o;
        r = {a[ZW-1], a};
        if (r > HALF_TURN) begin
            r = r - FULL_TURN;
        end else if (r <= -HALF_TURN) begin
            r = r + FULL_TURN;
        end
        o.neg = 1'b0;
        if (r > QUARTER_TURN) begin
            r = r - HALF_TURN;
            o.neg = 1'b1;
        end else if (r < -QUARTER_TURN) begin
            r = r + HALF_TURN;
            o.neg = 1'b1;
        end
        o.r = r[ZW-1:0];
        return o;
    endfunction

    logic                 adv;
    logic                 in_acc;
    logic [LAT-1:0]       r_vld;
    logic [RADIUS_W-1:0]  r_radius;

    assign adv = !(o_m_tvalid && !i_m_tready && r_vld[LAT-1]);
    assign o_s_tready = adv;
    assign in_acc = i_s_tvalid && adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (i_cfg_valid) begin
            r_radius <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[LAT-2:0], in_acc};
        end
    end

    // Half angle differences and latitudes in the CORDIC angle unit.
    logic signed [30:0]   hl, pl;
    logic signed [31:0]   ho, po;
    logic signed [ZW-1:0] n_dlat, n_dlon, n_lat1, n_lat2;
    logic signed [ZW-1:0] r_dlat, r_dlon, r_lat1, r_lat2;

    assign hl = i_s_tdata[30:0];
    assign ho = i_s_tdata[62:31];
    assign pl = i_s_tdata[93:63];
    assign po = i_s_tdata[125:94];

    always_comb begin
        n_dlat = (ZW'(pl) - ZW'(hl)) << 3;
        n_dlon = (ZW'(po) - ZW'(ho)) << 3;
        n_lat1 = ZW'(hl) << 4;
        n_lat2 = ZW'(pl) << 4;
    end

    t_ang r_f_dlat, r_f_dlon, r_f_lat1, r_f_lat2;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dlat <= n_dlat;
            r_dlon <= n_dlon;
            r_lat1 <= n_lat1;
            r_lat2 <= n_lat2;
            r_f_dlat <= fold(r_dlat);
            r_f_dlon <= fold(r_dlon);
            r_f_lat1 <= fold(r_lat1);
            r_f_lat2 <= fold(r_lat2);
        end
    end

    logic signed [XW-1:0] sin1, sin2, cos1, cos2;

    hgcd_cordic #(.XW(XW), .MODE(1'b0)) u_sin_dlat (
        .i_clk(i_clk), .i_en(adv), .i_x(GAIN), .i_y('0), .i_z(r_f_dlat.r),
        .o_x(), .o_y(sin1), .o_z()
    );

    hgcd_cordic #(.XW(XW), .MODE(1'b0)) u_sin_dlon (
        .i_clk(i_clk), .i_en(adv), .i_x(GAIN), .i_y('0), .i_z(r_f_dlon.r),
        .o_x(), .o_y(sin2), .o_z()
    );

    hgcd_cordic #(.XW(XW), .MODE(1'b0)) u_cos_lat1 (
        .i_clk(i_clk), .i_en(adv), .i_x(GAIN), .i_y('0), .i_z(r_f_lat1.r),
        .o_x(cos1), .o_y(), .o_z()
    );

    hgcd_cordic #(.XW(XW), .MODE(1'b0)) u_cos_lat2 (
        .i_clk(i_clk), .i_en(adv), .i_x(GAIN), .i_y('0), .i_z(r_f_lat2.r),
        .o_x(cos2), .o_y(), .o_z()
    );

    logic [1:0]           r_negd [ITERS];
    logic [MW-1:0]        r_s1, r_s2, r_c1, r_c2;
    logic                 r_cn;
    logic                 n_c1neg, n_c2neg;
    logic signed [XW-1:0] n_as1, n_as2, n_ac1, n_ac2;

    always_comb begin
        n_c1neg = r_negd[ITERS-1][0] ? (cos1 > 0) : (cos1 < 0);
        n_c2neg = r_negd[ITERS-1][1] ? (cos2 > 0) : (cos2 < 0);
        n_as1 = sin1 < 0 ? -sin1 : sin1;
        n_as2 = sin2 < 0 ? -sin2 : sin2;
        n_ac1 = cos1 < 0 ? -cos1 : cos1;
        n_ac2 = cos2 < 0 ? -cos2 : cos2;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_negd[0] <= {r_f_lat2.neg, r_f_lat1.neg};
            for (int i = 1; i < ITERS; i++) begin
                r_negd[i] <= r_negd[i-1];
            end
            r_s1 <= n_as1[MW-1:0];
            r_s2 <= n_as2[MW-1:0];
            r_c1 <= n_ac1[MW-1:0];
            r_c2 <= n_ac2[MW-1:0];
            r_cn <= n_c1neg ^ n_c2neg;
        end
    end

    logic [MW-1:0] sq1, sq2, m2, t2;
    logic [MW-1:0] r_c1d [2];
    logic [MW-1:0] r_c2d [4];
    logic [MW-1:0] r_t1d [4];
    logic          r_sgnd [6];

    hgcd_mul #(.AW(MW), .BW(MW), .SH(F), .OW(MW)) u_mul_s1 (
        .i_clk(i_clk), .i_en(adv), .i_a(r_s1), .i_b(r_s1), .o_p(sq1)
    );

    hgcd_mul #(.AW(MW), .BW(MW), .SH(F), .OW(MW)) u_mul_s2 (
        .i_clk(i_clk), .i_en(adv), .i_a(r_s2), .i_b(r_s2), .o_p(sq2)
    );

    hgcd_mul #(.AW(MW), .BW(MW), .SH(F), .OW(MW)) u_mul_c1 (
        .i_clk(i_clk), .i_en(adv), .i_a(sq2), .i_b(r_c1d[1]), .o_p(m2)
    );

    hgcd_mul #(.AW(MW), .BW(MW), .SH(F), .OW(MW)) u_mul_c2 (
        .i_clk(i_clk), .i_en(adv), .i_a(m2), .i_b(r_c2d[3]), .o_p(t2)
    );

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c1d[0] <= r_c1;
            r_c1d[1] <= r_c1d[0];
            r_c2d[0] <= r_c2;
            r_t1d[0] <= sq1;
            for (int i = 1; i < 4; i++) begin
                r_c2d[i] <= r_c2d[i-1];
                r_t1d[i] <= r_t1d[i-1];
            end
            r_sgnd[0] <= r_cn;
            for (int i = 1; i < 6; i++) begin
                r_sgnd[i] <= r_sgnd[i-1];
            end
        end
    end

    logic [MW:0] n_araw;
    logic [F:0]  n_a, r_a, r_b;

    always_comb begin
        if (r_sgnd[5]) begin
            n_araw = r_t1d[3] >= t2 ? (MW+1)'(r_t1d[3] - t2) : '0;
        end else begin
            n_araw = (MW+1)'(r_t1d[3]) + (MW+1)'(t2);
        end
        n_a = n_araw > (MW+1)'(ONE) ? ONE : n_araw[F:0];
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a <= n_a;
            r_b <= ONE - n_a;
        end
    end

    // Two square roots side by side, one result bit per stage.
    logic [NW-1:0] r_sq_n    [F+1][2];
    logic [RW-1:0] r_sq_rem  [F+1][2];
    logic [F:0]    r_sq_root [F+1][2];

    for (genvar s = 0; s <= F; s++) begin : g_sqrt
        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [NW-1:0] n_in;
            logic [RW-1:0] rem_in;
            logic [F:0]    root_in;
            logic [RW-1:0] n_rem;
            logic [RW-1:0] trial;
            logic          ge;

            if (s == 0) begin : g_first
                assign n_in = (l == 0) ? {1'b0, r_a, {F{1'b0}}} : {1'b0, r_b, {F{1'b0}}};
                assign rem_in = '0;
                assign root_in = '0;
            end else begin : g_next
                assign n_in = r_sq_n[s-1][l];
                assign rem_in = r_sq_rem[s-1][l];
                assign root_in = r_sq_root[s-1][l];
            end

            always_comb begin
                n_rem = {rem_in[RW-3:0], n_in[NW-1:NW-2]};
                trial = RW'({root_in, 2'b01});
                ge = n_rem >= trial;
            end

            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_sq_n[s][l] <= n_in << 2;
                    r_sq_rem[s][l] <= ge ? n_rem - trial : n_rem;
                    r_sq_root[s][l] <= {root_in[F-1:0], ge};
                end
            end
        end
    end

    logic signed [ZW-1:0] zang;

    hgcd_cordic #(.XW(XW), .MODE(1'b1)) u_atan2 (
        .i_clk(i_clk), .i_en(adv),
        .i_x($signed({2'b00, r_sq_root[F][1]})),
        .i_y($signed({2'b00, r_sq_root[F][0]})),
        .i_z('0),
        .o_x(), .o_y(), .o_z(zang)
    );

    logic [ZU_W-1:0]   r_zu;
    logic [PRW-1:0]    rz;
    logic [DIST_W-1:0] dist_raw;
    logic [DIST_W-1:0] r_out_d;
    logic              r_out_valid;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (zang < 0) begin
                r_zu <= '0;
            end else if ({zang[ZW-1], zang} > QUARTER_TURN) begin
                r_zu <= QUARTER_TURN[ZU_W-1:0];
            end else begin
                r_zu <= zang[ZU_W-1:0];
            end
        end
    end

    hgcd_mul #(.AW(RADIUS_W), .BW(ZU_W), .SH(0), .OW(PRW)) u_mul_r (
        .i_clk(i_clk), .i_en(adv), .i_a(r_radius), .i_b(r_zu), .o_p(rz)
    );

    hgcd_mul #(.AW(PRW), .BW(SCALE_W), .SH(DIST_SHIFT), .OW(DIST_W)) u_mul_k (
        .i_clk(i_clk), .i_en(adv), .i_a(rz), .i_b(DIST_SCALE), .o_p(dist_raw)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_m_tready) begin
            r_out_valid <= r_vld[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_m_tready) begin
            r_out_d <= dist_raw > DIST_MAX ? DIST_MAX : dist_raw;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata = {5'b0, r_out_d};

`ifndef NO_ASSERTIONS
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && !i_m_tready && r_vld[LAT-1]))
        else $error("pipeline stalled without a blocked result");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |=> $stable(r_vld))
        else $error("valid bits moved during a stall");

    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[DIST_W-1:0] <= DIST_MAX))
        else $error("distance above saturation limit");
`endif

endmodule

[sv/hgcd_mul.sv]
module hgcd_mul #(
    parameter int AW = 32,
    parameter int BW = 32,
    parameter int SH = 30,
    parameter int OW = 32
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [AW-1:0] i_a,
    input  logic [BW-1:0] i_b,
    output logic [OW-1:0] o_p
);

    localparam int HA = (AW + 1) / 2;
    localparam int HB = (BW + 1) / 2;
    localparam int PW = AW + BW;

    logic [HA+HB-1:0]           r_p00;
    logic [HA+BW-HB-1:0]        r_p01;
    logic [AW-HA+HB-1:0]        r_p10;
    logic [AW-HA+BW-HB-1:0]     r_p11;
    logic [PW-1:0]              n_sum;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p00 <= i_a[HA-1:0] * i_b[HB-1:0];
            r_p01 <= i_a[HA-1:0] * i_b[BW-1:HB];
            r_p10 <= i_a[AW-1:HA] * i_b[HB-1:0];
            r_p11 <= i_a[AW-1:HA] * i_b[BW-1:HB];
        end
    end

    always_comb begin
        n_sum = PW'(r_p00) + (PW'(r_p01) << HB) + (PW'(r_p10) << HA)
              + (PW'(r_p11) << (HA + HB));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_p <= n_sum[SH +: OW];
        end
    end

endmodule

[sv/hgcd_cordic.sv]
module hgcd_cordic import hgcd_pkg::*; #(
    parameter int XW   = 33,
    parameter bit MODE = 1'b0
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [XW-1:0] i_x,
    input  logic signed [XW-1:0] i_y,
    input  logic signed [ZW-1:0] i_z,
    output logic signed [XW-1:0] o_x,
    output logic signed [XW-1:0] o_y,
    output logic signed [ZW-1:0] o_z
);

    logic signed [XW-1:0] r_x [ITERS];
    logic signed [XW-1:0] r_y [ITERS];
    logic signed [ZW-1:0] r_z [ITERS];

    for (genvar g = 0; g < ITERS; g++) begin : g_stage
        logic signed [XW-1:0] x_in;
        logic signed [XW-1:0] y_in;
        logic signed [ZW-1:0] z_in;
        logic signed [XW-1:0] n_x;
        logic signed [XW-1:0] n_y;
        logic signed [ZW-1:0] n_z;
        logic                 up;

        if (g == 0) begin : g_first
            assign x_in = i_x;
            assign y_in = i_y;
            assign z_in = i_z;
        end else begin : g_next
            assign x_in = r_x[g-1];
            assign y_in = r_y[g-1];
            assign z_in = r_z[g-1];
        end

        assign up = MODE ? (y_in <= 0) : (z_in >= 0);

        always_comb begin
            if (up) begin
                n_x = x_in - (y_in >>> g);
                n_y = y_in + (x_in >>> g);
                n_z = z_in - ATAN_TAB[g];
            end else begin
                n_x = x_in + (y_in >>> g);
                n_y = y_in - (x_in >>> g);
                n_z = z_in + ATAN_TAB[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[g] <= n_x;
                r_y[g] <= n_y;
                r_z[g] <= n_z;
            end
        end
    end

    assign o_x = r_x[ITERS-1];
    assign o_y = r_y[ITERS-1];
    assign o_z = r_z[ITERS-1];

endmodule

[dv/testbench.sv]
module testbench import hgcd_pkg::*; ();

    localparam int FB = 30;
    localparam int LATENCY = FB + 80;
    localparam longint Q_TURN = 64'sd14400000000;
    localparam longint H_TURN = 64'sd28800000000;
    localparam longint F_TURN = 64'sd57600000000;
    localparam longint GAIN = 64'sd652032874;

    typedef struct packed {
        logic signed [31:0] point_lon;
        logic signed [30:0] point_lat;
        logic signed [31:0] here_lon;
        logic signed [30:0] here_lat;
    } t_query;

    typedef struct {
        t_query q;
        logic   has_exp;
        logic [34:0] exp_d;
    } t_row;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_s_tvalid = 0;
    logic o_s_tready;
    logic [127:0] i_s_tdata = '0;
    logic o_m_tvalid;
    logic i_m_tready = 0;
    logic [39:0] o_m_tdata;
    logic i_cfg_valid = 0;
    logic o_cfg_ready;
    logic [RADIUS_W-1:0] i_cfg_data = '0;

    logic [34:0] distance_queue[$];
    logic [25:0] radius_m;
    int errors = 0;

    always #5 i_clk = ~i_clk;

    haversine_great_circle_distance_core #(.ANGLE_FRAC_BITS(FB)) dut (.*);

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int s);
        logic [127:0] p;
        p = a * b;
        return 64'(p >> s);
    endfunction

    function automatic logic [63:0] magnitude(longint v);
        return v < 0 ? -v : v;
    endfunction

    task automatic rotate(input longint ang, output longint s, output longint c);
        longint r, x, y, dx, dy;
        bit neg;
        r = ang % F_TURN;
        neg = 0;
        if (r < 0) r += F_TURN;
        if (r > H_TURN) r -= F_TURN;
        if (r > Q_TURN) begin
            r -= H_TURN;
            neg = 1;
        end else if (r < -Q_TURN) begin
            r += H_TURN;
            neg = 1;
        end
        x = GAIN <<< (FB - 30);
        y = 0;
        for (int i = 0; i < ITERS; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (r >= 0) begin
                x -= dx; y += dy; r -= longint'(ATAN_TAB[i]);
            end else begin
                x += dx; y -= dy; r += longint'(ATAN_TAB[i]);
            end
        end
        s = neg ? -y : y;
        c = neg ? -x : x;
    endtask

    function automatic logic [63:0] fixed_root(logic [63:0] a);
        logic [127:0] v;
        logic [63:0] root, rem, trial;
        v = {64'd0, a} << FB;
        root = 0;
        rem = 0;
        for (int k = FB; k >= 0; k--) begin
            rem = (rem << 2) | 64'(v[2*k +: 2]);
            trial = (root << 2) | 1;
            if (rem >= trial) begin
                rem -= trial;
                root = (root << 1) | 1;
            end else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    function automatic longint half_angle(longint y, longint x);
        longint z, dx, dy;
        z = 0;
        for (int i = 0; i < ITERS; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (y > 0) begin
                x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
            end else begin
                x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
            end
        end
        return z;
    endfunction

    task automatic predict_distance(input t_query q, output logic [34:0] d);
        longint hl, ho, pl, po, s1, s2, c1, c2, unused, z;
        logic [63:0] t1, t2, a, one;
        logic [127:0] p;
        hl = q.here_lat; ho = q.here_lon; pl = q.point_lat; po = q.point_lon;
        one = 64'd1 << FB;
        rotate((pl - hl) * 8, s1, unused);
        rotate((po - ho) * 8, s2, unused);
        rotate(hl * 16, unused, c1);
        rotate(pl * 16, unused, c2);
        t1 = mul_shift(magnitude(s1), magnitude(s1), FB);
        t2 = mul_shift(mul_shift(mul_shift(magnitude(s2), magnitude(s2), FB),
                                 magnitude(c1), FB), magnitude(c2), FB);
        if ((c1 < 0) != (c2 < 0)) a = t1 >= t2 ? t1 - t2 : 0;
        else a = t1 + t2;
        if (a > one) a = one;
        z = half_angle(longint'(fixed_root(a)), longint'(fixed_root(one - a)));
        if (z < 0) z = 0;
        if (z > Q_TURN) z = Q_TURN;
        p = (128'(radius_m) * 128'(z)) * 128'(DIST_SCALE);
        p = p >> DIST_SHIFT;
        d = p > 128'(DIST_MAX) ? DIST_MAX : p[34:0];
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    task automatic send_query(input t_query q);
        logic [34:0] d;
        int gap;
        gap = $urandom_range(0, 19);
        if (gap > 0) begin
            i_s_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        predict_distance(q, d);
        distance_queue.push_back(d);
        i_s_tvalid <= 1;
        i_s_tdata <= {2'b00, q};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic send_row(input t_row r);
        logic [34:0] d;
        if (r.has_exp) begin
            predict_distance(r.q, d);
            if (d !== r.exp_d) report_mismatch($sformatf("table row exp %0d", r.exp_d));
        end
        send_query(r.q);
    endtask

    task automatic drain;
        i_s_tvalid <= 0;
        while (distance_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic write_radius(input logic [25:0] v);
        drain();
        i_cfg_valid <= 1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
        radius_m = v;
    endtask

    function automatic t_query rand_query(bit wide);
        t_query q;
        if (wide) begin
            q = 126'({$urandom, $urandom, $urandom, $urandom});
        end else begin
            q.here_lat = 31'(int'($urandom_range(0, 1800000000)) - 900000000);
            q.point_lat = 31'(int'($urandom_range(0, 1800000000)) - 900000000);
            q.here_lon = 32'(longint'($urandom_range(0, 32'd3600000000))
                             - 64'sd1800000000);
            q.point_lon = 32'(longint'($urandom_range(0, 32'd3600000000))
                              - 64'sd1800000000);
        end
        return q;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (distance_queue.size() == 0) begin
                    report_mismatch("unexpected result");
                end else begin
                    if (o_m_tdata[34:0] !== distance_queue[0])
                        report_mismatch($sformatf("distance got %0d exp %0d",
                                                  o_m_tdata[34:0], distance_queue[0]));
                    void'(distance_queue.pop_front());
                end
            end
        end
    end

    initial begin
        int gap;
        forever begin
            gap = $urandom_range(0, 19);
            if (gap > 0) begin
                i_m_tready <= 0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_tready <= 1;
            @(posedge i_clk);
            while (!o_m_tvalid) @(posedge i_clk);
        end
    end

    initial begin
        t_row rows[$];
        t_row r;
        radius_m = RADIUS_RESET;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        r.has_exp = 1; r.exp_d = 0; r.q = '0; rows.push_back(r);
        r.q = '{here_lat: 900000000, here_lon: 0, point_lat: 900000000, point_lon: 0};
        rows.push_back(r);
        r.has_exp = 0;
        r.q = '{here_lat: -900000000, here_lon: 0, point_lat: 900000000, point_lon: 0};
        rows.push_back(r);
        r.q = '{here_lat: 0, here_lon: -1800000000, point_lat: 0, point_lon: 1800000000};
        rows.push_back(r);
        r.q = '{here_lat: 0, here_lon: 0, point_lat: 0, point_lon: 1800000000};
        rows.push_back(r);
        r.q = '{here_lat: 31'h3fffffff, here_lon: 32'h7fffffff,
                point_lat: 31'h40000000, point_lon: 32'h80000000};
        rows.push_back(r);
        r.q = '{here_lat: 1200000000, here_lon: 100, point_lat: -1100000000, point_lon: 5};
        rows.push_back(r);
        r.q = '{here_lat: 1, here_lon: 0, point_lat: 0, point_lon: 1};
        rows.push_back(r);
        r.q = '{here_lat: 515000000, here_lon: -1200000, point_lat: 407000000,
                point_lon: -740000000};
        rows.push_back(r);
        r.q = '{here_lat: 31'h7fffffff, here_lon: 32'hffffffff,
                point_lat: 31'h7fffffff, point_lon: 32'hffffffff};
        rows.push_back(r);
        foreach (rows[i]) send_row(rows[i]);

        write_radius(26'h3ffffff);
        foreach (rows[i]) begin
            r = rows[i];
            r.has_exp = 0;
            send_row(r);
        end
        write_radius(26'd0);
        for (int i = 0; i < 4; i++) send_query(rand_query(0));
        write_radius(26'd1);
        for (int i = 0; i < 4; i++) send_query(rand_query(0));

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: write_radius(RADIUS_RESET);
                1: write_radius(26'($urandom_range(1, 26'h3ffffff)));
                2: write_radius(26'($urandom_range(1, 1000)));
                default: write_radius(26'h3ffffff);
            endcase
            for (int i = 0; i < 220; i++) begin
                send_query(rand_query($urandom_range(0, 9) == 0));
                if (i == 100 && phase == 1) drain();
            end
        end
        drain();
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
